// ===== src/slotted_page_directory_macros.svh =====
// Assertion macros used by the slotted page directory top level.
`ifndef SLOTTED_PAGE_DIRECTORY_MACROS_SVH
`define SLOTTED_PAGE_DIRECTORY_MACROS_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define SPD_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slotted page directory check failed");
// Antecedent implies consequent in the next cycle.
`define SPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slotted page directory check failed");
`else
`define SPD_ASSERT_IMPLY(lbl, ante, cons)
`define SPD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/spd_pkg.sv =====
// Types and constants of the slotted page directory.
`timescale 1ns / 1ps
package spd_pkg;
  localparam int SLOT_W = 11;
  localparam int OFF_W  = 13;
  localparam int LEN_W  = 14;
  localparam int OP_W   = 3;
  localparam int DEPTH  = 2048;
  localparam logic [SLOT_W-1:0] MAX_SLOT = 11'd2047;

  // Page size; the offset and length fields are sized for it.
  localparam int PAGE_BYTES = 8192;

  localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
  localparam logic [OP_W-1:0] OP_RESTORE  = 3'd2;
  localparam logic [OP_W-1:0] OP_REDIRECT = 3'd3;
  localparam logic [OP_W-1:0] OP_GET      = 3'd4;
  localparam logic [OP_W-1:0] OP_UPDATE   = 3'd5;
  localparam logic [OP_W-1:0] OP_INIT     = 3'd6;

  localparam logic [1:0] FL_UNUSED   = 2'd0;
  localparam logic [1:0] FL_NORMAL   = 2'd1;
  localparam logic [1:0] FL_REDIRECT = 2'd2;

  // One line pointer as stored in the directory.
  typedef struct packed {
    logic [1:0]       flags;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } entry_t;

  // Access request to the directory store.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic [SLOT_W-1:0] raddr;
  } dir_req_t;
endpackage

// ===== src/slotted_page_directory.sv =====
// Top level of the slotted page line pointer directory.
//
//  Channel   Dir  Beat fields (tdata, lowest bit first)
//  s_axis    in   op[2:0] slot[13:3] target_slot[24:14] length[38:25]
//  m_axis    out  ok[0] slot_out[11:1] byte_offset[24:12] length_out[38:25]
//                 free_bytes[52:39]
//
// One request at a time; the shared directory port does one read a cycle.
// Init and slot or op refusals go straight to the result; a get walks the redirect chain
// hop by hop up to MAX_HOPS, and an insert scans the slots in order before it appends;
// a moving update frees its slot and then inserts.
// Reset restores the empty page at once; the store needs no clearing.
// A result beat waits in the output register while the next request runs.
`timescale 1ns / 1ps
module slotted_page_directory #(
  parameter int HEADER_BYTES  = 24,
  parameter int POINTER_BYTES = 4,
  parameter int TRAILER_BYTES = 4,
  parameter int MAX_HOPS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op, slot, target_slot, length
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // ok, slot_out, byte_offset, length_out, free_bytes
  output logic [55:0] m_axis_tdata
);
  import spd_pkg::*;
`include "slotted_page_directory_macros.svh"

  localparam int BW    = $clog2(PAGE_BYTES + 1);
  localparam int HOP_W = $clog2(MAX_HOPS + 1);
  localparam int MAX_LEN = PAGE_BYTES - HEADER_BYTES - POINTER_BYTES;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DISP   = 4'd1;
  localparam logic [3:0] ST_RDS    = 4'd2;
  localparam logic [3:0] ST_EVS    = 4'd3;
  localparam logic [3:0] ST_RDT    = 4'd4;
  localparam logic [3:0] ST_EVT    = 4'd5;
  localparam logic [3:0] ST_HOP    = 4'd6;
  localparam logic [3:0] ST_HOPEV  = 4'd7;
  localparam logic [3:0] ST_INS    = 4'd8;
  localparam logic [3:0] ST_SCAN   = 4'd9;
  localparam logic [3:0] ST_SCANEV = 4'd10;
  localparam logic [3:0] ST_APPEND = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  logic [3:0]        state, state_next;
  logic [OP_W-1:0]   op_r, op_r_next;
  logic [SLOT_W-1:0] s_r, s_r_next, t_r, t_r_next;
  logic [LEN_W-1:0]  len_r, len_r_next;
  entry_t            ent, ent_next;
  logic [OFF_W-1:0]  tg, tg_next;
  logic [HOP_W-1:0]  hop, hop_next;
  logic [SLOT_W-1:0] idx, idx_next;
  logic [SLOT_W-1:0] n, n_next;
  logic [BW-1:0]     lower, lower_next, upper, upper_next;
  logic              mark, mark_next;
  logic              res_ok, res_ok_next;
  logic [SLOT_W-1:0] res_slot, res_slot_next;
  logic [OFF_W-1:0]  res_off, res_off_next;
  logic [LEN_W-1:0]  res_len, res_len_next;
  logic              out_valid, out_valid_next;
  logic [55:0]       out_data, out_data_next;

  dir_req_t          req;
  entry_t            rdata;
  logic              ins_fail, commit;
  logic [SLOT_W-1:0] commit_slot;
  logic [31:0]       free32, newtop32;
  logic              s_ok, reuse_ok, room_ok, len_bad;

  spd_dir_store u_store (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Bound arithmetic shared by every insert path, and the source slot check.
  assign free32   = 32'(upper) - 32'(lower);
  assign newtop32 = 32'(upper) - 32'(len_r);
  assign reuse_ok = (free32 >= 32'(POINTER_BYTES)) &&
                    (32'(len_r) <= free32 - 32'(POINTER_BYTES));
  assign room_ok  = 32'(upper) >= 32'(lower) + 32'(POINTER_BYTES) + 32'(len_r);
  assign len_bad  = (len_r == '0) || (32'(len_r) > 32'(MAX_LEN));
  assign s_ok     = (s_r != '0) && (s_r <= n);

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Request sequencer.
  always_comb begin
    state_next     = state;
    op_r_next      = op_r;
    s_r_next       = s_r;
    t_r_next       = t_r;
    len_r_next     = len_r;
    ent_next       = ent;
    tg_next        = tg;
    hop_next       = hop;
    idx_next       = idx;
    n_next         = n;
    lower_next     = lower;
    upper_next     = upper;
    mark_next      = mark;
    res_ok_next    = res_ok;
    res_slot_next  = res_slot;
    res_off_next   = res_off;
    res_len_next   = res_len;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    req            = '0;
    ins_fail       = 1'b0;
    commit         = 1'b0;
    commit_slot    = idx;

    if (out_valid && m_axis_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_r_next  = s_axis_tdata[2:0];
          s_r_next   = s_axis_tdata[13:3];
          t_r_next   = s_axis_tdata[24:14];
          len_r_next = s_axis_tdata[38:25];
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        res_ok_next   = 1'b0;
        res_slot_next = '0;
        res_off_next  = '0;
        res_len_next  = '0;
        state_next    = ST_DONE;
        case (op_r)
          OP_INSERT: state_next = ST_INS;
          OP_REMOVE, OP_RESTORE, OP_REDIRECT, OP_GET, OP_UPDATE: begin
            if (s_ok) state_next = ST_RDS;
          end
          OP_INIT: begin
            lower_next  = BW'(HEADER_BYTES);
            upper_next  = BW'(PAGE_BYTES - TRAILER_BYTES);
            n_next      = '0;
            mark_next   = 1'b0;
            res_ok_next = 1'b1;
          end
          default: ;
        endcase
      end
      ST_RDS: begin
        req.raddr  = s_r;
        state_next = ST_EVS;
      end
      ST_EVS: begin
        ent_next   = rdata;
        state_next = ST_DONE;
        req.waddr  = s_r;
        req.wdata  = rdata;
        case (op_r)
          OP_REMOVE: begin
            if (rdata.flags == FL_NORMAL) begin
              req.we          = 1'b1;
              req.wdata.flags = FL_UNUSED;
              mark_next       = 1'b1;
              res_ok_next     = 1'b1;
              res_slot_next   = s_r;
              res_off_next    = rdata.off;
              res_len_next    = rdata.len;
            end
          end
          OP_RESTORE: begin
            if (rdata.flags == FL_UNUSED && rdata.len != '0) begin
              req.we          = 1'b1;
              req.wdata.flags = FL_NORMAL;
              res_ok_next     = 1'b1;
              res_slot_next   = s_r;
              res_off_next    = rdata.off;
              res_len_next    = rdata.len;
            end
          end
          OP_REDIRECT: begin
            if (rdata.flags == FL_NORMAL && t_r != '0 && t_r <= n) begin
              state_next = ST_RDT;
            end
          end
          OP_GET: begin
            if (rdata.flags == FL_NORMAL) begin
              res_ok_next   = 1'b1;
              res_slot_next = s_r;
              res_off_next  = rdata.off;
              res_len_next  = rdata.len;
            end else if (rdata.flags == FL_REDIRECT) begin
              tg_next    = rdata.off;
              hop_next   = '0;
              state_next = ST_HOP;
            end
          end
          default: begin
            // Update: shrink in place, or free the slot and reinsert.
            if (rdata.flags == FL_NORMAL) begin
              req.we = 1'b1;
              if (len_r <= rdata.len) begin
                req.wdata.len = len_r;
                res_ok_next   = 1'b1;
                res_slot_next = s_r;
                res_off_next  = rdata.off;
                res_len_next  = len_r;
              end else begin
                req.wdata.flags = FL_UNUSED;
                mark_next       = 1'b1;
                state_next      = ST_INS;
              end
            end
          end
        endcase
      end
      ST_RDT: begin
        req.raddr  = t_r;
        state_next = ST_EVT;
      end
      ST_EVT: begin
        state_next = ST_DONE;
        if (rdata.flags == FL_NORMAL) begin
          req.we          = 1'b1;
          req.waddr       = s_r;
          req.wdata.flags = FL_REDIRECT;
          req.wdata.off   = OFF_W'(t_r);
          req.wdata.len   = '0;
          res_ok_next     = 1'b1;
          res_slot_next   = s_r;
        end
      end
      ST_HOP: begin
        // Stop when out of hops or the target leaves the directory.
        if (32'(hop) == 32'(MAX_HOPS) || tg == '0 || tg > OFF_W'(n)) begin
          state_next = ST_DONE;
        end else begin
          req.raddr  = tg[SLOT_W-1:0];
          state_next = ST_HOPEV;
        end
      end
      ST_HOPEV: begin
        if (rdata.flags != FL_REDIRECT) begin
          state_next = ST_DONE;
          if (rdata.flags == FL_NORMAL) begin
            res_ok_next   = 1'b1;
            res_slot_next = tg[SLOT_W-1:0];
            res_off_next  = rdata.off;
            res_len_next  = rdata.len;
          end
        end else begin
          tg_next    = rdata.off;
          hop_next   = hop + 1'b1;
          state_next = ST_HOP;
        end
      end
      ST_INS: begin
        if (len_bad) begin
          ins_fail = 1'b1;
        end else if (n == '0) begin
          state_next = ST_APPEND;
        end else begin
          idx_next   = SLOT_W'(1);
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        req.raddr  = idx;
        state_next = ST_SCANEV;
      end
      ST_SCANEV: begin
        // The first unused slot is reused only if space allows.
        if (rdata.flags == FL_UNUSED) begin
          if (reuse_ok) begin
            commit = 1'b1;
          end else begin
            state_next = ST_APPEND;
          end
        end else if (idx == n) begin
          state_next = ST_APPEND;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_APPEND: begin
        if (n == MAX_SLOT || !room_ok) begin
          ins_fail = 1'b1;
        end else begin
          commit      = 1'b1;
          commit_slot = n + 1'b1;
          n_next      = n + 1'b1;
          lower_next  = lower + BW'(POINTER_BYTES);
        end
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = {3'b000, free32[LEN_W-1:0], res_len, res_off, res_slot, res_ok};
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    // Take tuple space below the upper bound.
    if (commit) begin
      req.we          = 1'b1;
      req.waddr       = commit_slot;
      req.wdata.flags = FL_NORMAL;
      req.wdata.off   = newtop32[OFF_W-1:0];
      req.wdata.len   = len_r;
      upper_next      = newtop32[BW-1:0];
      res_ok_next     = 1'b1;
      res_slot_next   = commit_slot;
      res_off_next    = newtop32[OFF_W-1:0];
      res_len_next    = len_r;
      state_next      = ST_DONE;
    end

    // A failed insert refuses; a failed update puts the old entry back.
    if (ins_fail) begin
      state_next    = ST_DONE;
      res_ok_next   = 1'b0;
      res_slot_next = '0;
      res_off_next  = '0;
      res_len_next  = '0;
      if (op_r == OP_UPDATE) begin
        req.we          = 1'b1;
        req.waddr       = s_r;
        req.wdata       = ent;
        req.wdata.flags = FL_NORMAL;
        res_slot_next   = s_r;
        res_off_next    = ent.off;
        res_len_next    = ent.len;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      n         <= '0;
      lower     <= BW'(HEADER_BYTES);
      upper     <= BW'(PAGE_BYTES - TRAILER_BYTES);
      mark      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      n         <= n_next;
      lower     <= lower_next;
      upper     <= upper_next;
      mark      <= mark_next;
      out_valid <= out_valid_next;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    op_r     <= op_r_next;
    s_r      <= s_r_next;
    t_r      <= t_r_next;
    len_r    <= len_r_next;
    ent      <= ent_next;
    tg       <= tg_next;
    hop      <= hop_next;
    idx      <= idx_next;
    res_ok   <= res_ok_next;
    res_slot <= res_slot_next;
    res_off  <= res_off_next;
    res_len  <= res_len_next;
    out_data <= out_data_next;
  end

  `SPD_ASSERT_IMPLY(a_lower_tracks_count, 1'b1,
    32'(lower) == 32'(HEADER_BYTES) + 32'(n) * 32'(POINTER_BYTES))
  `SPD_ASSERT_IMPLY(a_bounds_order, 1'b1, upper >= lower)
  `SPD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, state == ST_DISP)
endmodule

// ===== src/spd_dir_store.sv =====
// Line pointer store: one write and one registered read per cycle.
`timescale 1ns / 1ps
module spd_dir_store (
  input  logic              clk,
  input  spd_pkg::dir_req_t req,
  output spd_pkg::entry_t   rdata
);
  import spd_pkg::*;

  entry_t mem [DEPTH];

  // Write and read ports; a read returns registered data in the next cycle.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the slotted page line pointer directory.
`timescale 1ns / 1ps
module tb;
  import spd_pkg::*;

  localparam int PAGE       = 8192;
  localparam int HEADER     = 24;
  localparam int PTR        = 4;
  localparam int TRAILER    = 4;
  localparam int HOPS       = 16;
  localparam int MAX_TUPLE  = PAGE - HEADER - PTR;
  localparam int IDLE_LIMIT = 40000;
  localparam int RANDOM_REQ = 1400;

  // Result beat, first field in the lowest bits.
  typedef struct packed {
    logic [2:0]       pad;
    logic [LEN_W-1:0] free;
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] off;
    logic [SLOT_W-1:0] slot;
    logic             ok;
  } page_reply_t;

  // One row of the directed part.
  typedef struct {
    logic [OP_W-1:0]   op;
    int                slot;
    int                tgt;
    int                len;
    bit                typed;
    page_reply_t       want;
  } page_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;

  slotted_page_directory i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Shadow copy of the page.
  logic [1:0]       pg_flags [DEPTH];
  logic [OFF_W-1:0] pg_off   [DEPTH];
  logic [LEN_W-1:0] pg_len   [DEPTH];
  int unsigned      pg_lower;
  int unsigned      pg_upper;

  page_reply_t pending_replies[$];
  int          fail_count;
  int          idle_cycles;
  bit          stall_free;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned slot_count();
    if (pg_lower <= HEADER) return 0;
    return (pg_lower - HEADER) / PTR;
  endfunction

  function automatic int unsigned free_space();
    return (pg_upper > pg_lower) ? pg_upper - pg_lower : 0;
  endfunction

  function automatic void empty_page();
    pg_lower = HEADER;
    pg_upper = PAGE - TRAILER;
  endfunction

  function automatic void write_pointer(int unsigned s, logic [1:0] fl,
                                        int unsigned o, int unsigned l);
    pg_flags[s] = fl;
    pg_off[s]   = o[OFF_W-1:0];
    pg_len[s]   = l[LEN_W-1:0];
  endfunction

  // Places a tuple: lowest unused slot first, else a new pointer. 0 if refused.
  function automatic int unsigned place_tuple(int unsigned len);
    int unsigned n;
    int unsigned fr;
    n  = slot_count();
    fr = free_space();
    if (len == 0 || len > MAX_TUPLE) return 0;
    for (int unsigned i = 1; i <= n && i <= 2047; i++) begin
      if (pg_flags[i] == FL_UNUSED) begin
        if (fr >= PTR && len <= fr - PTR) begin
          pg_upper -= len;
          write_pointer(i, FL_NORMAL, pg_upper, len);
          return i;
        end
        break;
      end
    end
    if (n + 1 > 2047) return 0;
    if (pg_upper < pg_lower + PTR + len) return 0;
    pg_upper -= len;
    write_pointer(n + 1, FL_NORMAL, pg_upper, len);
    pg_lower += PTR;
    return n + 1;
  endfunction

  // Applies one request to the shadow page and returns its result beat.
  function automatic page_reply_t apply_request(logic [OP_W-1:0] op, int unsigned s,
                                                int unsigned t, int unsigned len);
    page_reply_t r;
    int unsigned n;
    int unsigned cur;
    int unsigned tg;
    int unsigned got;
    logic [1:0]  fl;
    bit          hit;
    r   = '0;
    n   = slot_count();
    hit = (s != 0 && s <= n);
    case (op)
      OP_INSERT: begin
        got = place_tuple(len);
        if (got != 0) begin
          r.ok = 1'b1; r.slot = SLOT_W'(got); r.off = pg_off[got]; r.len = pg_len[got];
        end
      end
      OP_REMOVE: begin
        if (hit && pg_flags[s] == FL_NORMAL) begin
          pg_flags[s] = FL_UNUSED;
          r.ok = 1'b1; r.slot = SLOT_W'(s); r.off = pg_off[s]; r.len = pg_len[s];
        end
      end
      OP_RESTORE: begin
        if (hit && pg_flags[s] == FL_UNUSED && pg_len[s] != 0) begin
          pg_flags[s] = FL_NORMAL;
          r.ok = 1'b1; r.slot = SLOT_W'(s); r.off = pg_off[s]; r.len = pg_len[s];
        end
      end
      OP_REDIRECT: begin
        if (hit && t != 0 && t <= n && pg_flags[s] == FL_NORMAL &&
            pg_flags[t] == FL_NORMAL) begin
          write_pointer(s, FL_REDIRECT, t, 0);
          r.ok = 1'b1; r.slot = SLOT_W'(s);
        end
      end
      OP_GET: begin
        if (hit) begin
          cur = s;
          fl  = pg_flags[s];
          // Walk the chain; a chain still redirecting after the hop limit fails.
          if (fl == FL_REDIRECT) begin
            tg = 32'(pg_off[s]);
            for (int hop = 0; hop < HOPS && tg != 0 && tg <= n; hop++) begin
              if (pg_flags[tg] != FL_REDIRECT) begin
                cur = tg;
                fl  = pg_flags[tg];
                break;
              end
              tg = 32'(pg_off[tg]);
            end
          end
          if (fl == FL_NORMAL) begin
            r.ok = 1'b1; r.slot = SLOT_W'(cur); r.off = pg_off[cur]; r.len = pg_len[cur];
          end
        end
      end
      OP_UPDATE: begin
        if (hit && pg_flags[s] == FL_NORMAL) begin
          if (len <= pg_len[s]) begin
            pg_len[s] = len[LEN_W-1:0];
            r.ok = 1'b1; r.slot = SLOT_W'(s); r.off = pg_off[s]; r.len = len[LEN_W-1:0];
          end else begin
            pg_flags[s] = FL_UNUSED;
            got = place_tuple(len);
            if (got != 0) begin
              r.ok = 1'b1; r.slot = SLOT_W'(got); r.off = pg_off[got];
              r.len = pg_len[got];
            end else begin
              // Move failed: the old tuple comes back.
              pg_flags[s] = FL_NORMAL;
              r.slot = SLOT_W'(s); r.off = pg_off[s]; r.len = pg_len[s];
            end
          end
        end
      end
      OP_INIT: begin
        empty_page();
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.free = LEN_W'(free_space());
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    fail_count++;
  endtask

  // Sends one request beat and records its expected result on acceptance.
  task automatic send_request(logic [OP_W-1:0] op, int unsigned s, int unsigned t,
                              int unsigned len, bit typed, page_reply_t want);
    page_reply_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, len[LEN_W-1:0], t[SLOT_W-1:0], s[SLOT_W-1:0], op};
    do @(posedge clk); while (!s_axis_tready);
    r = apply_request(op, s, t, len);
    pending_replies.push_back(typed ? want : r);
    @(negedge clk);
  endtask

  task automatic pause_sender(int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic page_reply_t refused(int unsigned fr);
    page_reply_t r;
    r = '0;
    r.free = LEN_W'(fr);
    return r;
  endfunction

  function automatic page_reply_t granted(int unsigned s, int unsigned o,
                                         int unsigned l, int unsigned fr);
    page_reply_t r;
    r = '0;
    r.ok = 1'b1; r.slot = SLOT_W'(s); r.off = OFF_W'(o); r.len = LEN_W'(l);
    r.free = LEN_W'(fr);
    return r;
  endfunction

  // Receiver stalls: random stretches, some with no stall at all.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_free) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    stall_free = 1'b0;
    forever begin
      repeat ($urandom_range(20, 300)) @(posedge clk);
      stall_free = ~stall_free;
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    page_reply_t got;
    page_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[55:0];
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = pending_replies.pop_front();
        if (got.ok   !== want.ok)
          report_mismatch("ok", int'(got.ok), int'(want.ok));
        if (got.slot !== want.slot)
          report_mismatch("slot_out", int'(got.slot), int'(want.slot));
        if (got.off  !== want.off)
          report_mismatch("byte_offset", int'(got.off), int'(want.off));
        if (got.len  !== want.len)
          report_mismatch("length_out", int'(got.len), int'(want.len));
        if (got.free !== want.free)
          report_mismatch("free_bytes", int'(got.free), int'(want.free));
        if (got.pad  !== 3'b000)
          report_mismatch("tdata padding", int'(got.pad), 0);
      end
    end
  end

  // Watchdog on cycles with no beat moving on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("slotted_page_directory test failed");
        $finish;
      end
    end
  end

  initial begin
    page_row_t   rows[$];
    page_reply_t none;
    logic [OP_W-1:0] op;
    int unsigned s;
    int unsigned t;
    int unsigned len;
    int unsigned n;
    int          pick;
    int          burst;
    none          = '0;
    fail_count    = 0;
    idle_cycles   = 0;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    empty_page();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: empty page, full page, free space under one pointer, each op.
    rows.push_back('{OP_GET,     1,    0,     0,    1, refused(8164)});
    rows.push_back('{OP_INSERT,  0,    0,     0,    1, refused(8164)});
    rows.push_back('{OP_INSERT,  0,    0,  8165,    1, refused(8164)});
    rows.push_back('{OP_INSERT,  0,    0,  8164,    1, refused(8164)});
    rows.push_back('{OP_INSERT,  0,    0, 16383,    1, refused(8164)});
    rows.push_back('{OP_INSERT,  0,    0,  8160,    1, granted(1, 28, 8160, 0)});
    rows.push_back('{OP_INSERT,  0,    0,     1,    1, refused(0)});
    rows.push_back('{OP_REMOVE,  1,    0,     0,    1, granted(1, 28, 8160, 0)});
    rows.push_back('{OP_INSERT,  0,    0,    10,    1, refused(0)});
    rows.push_back('{OP_RESTORE, 1,    0,     0,    1, granted(1, 28, 8160, 0)});
    rows.push_back('{OP_INIT,    2047, 2047, 16383, 1, granted(0, 0, 0, 8164)});
    rows.push_back('{OP_INSERT,  0,    0,   100,    0, none});
    rows.push_back('{OP_INSERT,  0,    0,   200,    0, none});
    rows.push_back('{OP_INSERT,  0,    0,   300,    0, none});
    rows.push_back('{OP_REDIRECT, 1,   2,     0,    0, none});
    rows.push_back('{OP_GET,     1,    0,     0,    0, none});
    rows.push_back('{OP_REDIRECT, 2,   2,     0,    0, none});
    rows.push_back('{OP_GET,     1,    0,     0,    0, none});
    rows.push_back('{OP_REDIRECT, 3,   0,     0,    0, none});
    rows.push_back('{OP_UPDATE,  3,    0,    50,    0, none});
    rows.push_back('{OP_UPDATE,  3,    0,   500,    0, none});
    rows.push_back('{OP_UPDATE,  4,    0,  8000,    0, none});
    rows.push_back('{OP_REMOVE,  4,    0,     0,    0, none});
    rows.push_back('{OP_RESTORE, 4,    0,     0,    0, none});
    rows.push_back('{3'd7,       2047, 2047, 16383, 0, none});
    foreach (rows[i]) begin
      send_request(rows[i].op, rows[i].slot, rows[i].tgt, rows[i].len,
                   rows[i].typed, rows[i].want);
    end

    // Random part: bursts of requests, mostly aimed at live slots.
    burst = 0;
    for (int k = 0; k < RANDOM_REQ; k++) begin
      if (k == RANDOM_REQ / 2) begin
        s_axis_tvalid <= 1'b0;
        wait (pending_replies.size() == 0);
        @(negedge clk);
      end
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        pause_sender($urandom_range(0, 12));
      end
      burst--;
      n    = slot_count();
      pick = $urandom_range(0, 99);
      if      (pick < 30) op = OP_INSERT;
      else if (pick < 42) op = OP_REMOVE;
      else if (pick < 50) op = OP_RESTORE;
      else if (pick < 60) op = OP_REDIRECT;
      else if (pick < 80) op = OP_GET;
      else if (pick < 96) op = OP_UPDATE;
      else if (pick < 98) op = OP_INIT;
      else                op = 3'd7;
      s = ($urandom_range(0, 9) < 8) ? $urandom_range(1, n + 1) : $urandom_range(0, 2047);
      t = ($urandom_range(0, 9) < 8) ? $urandom_range(1, n + 1) : $urandom_range(0, 2047);
      pick = $urandom_range(0, 99);
      if      (pick < 70) len = $urandom_range(1, 120);
      else if (pick < 85) len = $urandom_range(121, 2000);
      else if (pick < 95) len = $urandom_range(0, 8192);
      else                len = $urandom_range(0, 16383);
      send_request(op, s, t, len, 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    wait (pending_replies.size() == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("slotted_page_directory test passed");
    end else begin
      $display("slotted_page_directory test failed");
    end
    $finish;
  end
endmodule
